// ===== rtl/gss_pkg.sv =====
package gss_pkg;

    // number of coefficient bytes in one input word, secret included
    localparam int NUM_COEFS = 8;

    // share count saturates here
    localparam logic [3:0] MAX_SHARES = 4'd8;

    // field reduction for x^8 + x^4 + x^3 + x + 1
    localparam logic [7:0] GF_REDUCE = 8'h1B;
    localparam logic [7:0] GF_TOPBIT = 8'h80;

    // register indexes on the configuration port
    localparam logic REG_SHARE_COUNT = 1'b0;
    localparam logic REG_THRESHOLD   = 1'b1;

    typedef struct packed {
        logic [7:0] secret_byte;
        logic [7:0] coef_one;
        logic [7:0] coef_two;
        logic [7:0] coef_three;
        logic [7:0] coef_four;
        logic [7:0] coef_five;
        logic [7:0] coef_six;
        logic [7:0] coef_seven;
    } in_word_t;

    typedef struct packed {
        logic [3:0] share_x;
        logic [7:0] share_y;
        logic       last_share;
    } out_word_t;

    typedef logic [NUM_COEFS-1:0][7:0] coef_vec_t;

    // one evaluation point travelling down the chain
    typedef struct packed {
        logic [3:0] x;
        logic       last;
        logic [7:0] y;
        coef_vec_t  coefs;
    } token_t;

    // GF(2^8) multiply, shift and add
    function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] p;
        acc = 8'h00;
        p   = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i])
            begin
                acc = acc ^ p;
            end
            if ((p & GF_TOPBIT) != 8'h00)
            begin
                p = (p << 1) ^ GF_REDUCE;
            end
            else
            begin
                p = p << 1;
            end
        end
        return acc;
    endfunction

endpackage

// ===== rtl/gf256_shamir_share_split_unit.sv =====
// Shamir share split over GF(2^8), reduction polynomial 0x11B.
// item channel: one secret byte with seven coefficient bytes per word,
// accepted when item_valid is high and item_stall is low.
// share channel: share_count words per item (saturated at eight), share_x
// running 1 upward, last_share set on the final one; a share count of zero
// gives no words.
// Configuration through the APB port: share_count at address 0, threshold at
// address 4; both are sampled when an item is accepted.
// Throughput: one share word per cycle while share_stall does not hold a
// word up; the x sequencer feeds a chain of MAX_THRESHOLD horner cells.
// Each x runs from the sequencer register through the cells to the output register.
// The next item is taken in the cycle its predecessor's last x enters the chain.
// When share_stall is held with a word waiting, the whole chain and the
// sequencer freeze; nothing is dropped, item_stall rises once the sequencer
// is busy.
// Reset clears all valid bits and sets share_count to 5 and threshold to 3.
module gf256_shamir_share_split_unit #(
    parameter int MAX_THRESHOLD = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input words
    input  logic               item_valid,
    output logic               item_stall,
    input  gss_pkg::in_word_t  item,
    // share words
    output logic               share_valid,
    input  logic               share_stall,
    output gss_pkg::out_word_t share
);

    logic [3:0]         share_count_reg;
    logic [3:0]         threshold_reg;
    logic               share_valid_reg;
    gss_pkg::out_word_t share_reg;
    logic               adv;
    logic               reg_sel;

    logic            tok_valid [MAX_THRESHOLD+1];
    gss_pkg::token_t tok       [MAX_THRESHOLD+1];

    // register file
    assign pready  = 1'b1;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            share_count_reg <= 4'd5;
            threshold_reg   <= 4'd3;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_sel)
                gss_pkg::REG_SHARE_COUNT: share_count_reg <= pwdata[3:0];
                gss_pkg::REG_THRESHOLD:   threshold_reg   <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            gss_pkg::REG_SHARE_COUNT: prdata = {28'd0, share_count_reg};
            gss_pkg::REG_THRESHOLD:   prdata = {28'd0, threshold_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    // chain moves unless a share word is held up
    assign adv = !(share_valid_reg && share_stall);

    gss_issue #(
        .MAX_THRESHOLD(MAX_THRESHOLD)
    ) u_issue (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .share_count (share_count_reg),
        .threshold   (threshold_reg),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .tok_valid   (tok_valid[0]),
        .tok         (tok[0])
    );

    // horner cells, highest coefficient first
    for (genvar k = 0; k < MAX_THRESHOLD; k++)
    begin : g_cell
        gss_cell #(
            .COEF_IDX(MAX_THRESHOLD - 1 - k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .tok_valid (tok_valid[k]),
            .tok       (tok[k]),
            .out_valid (tok_valid[k+1]),
            .out_tok   (tok[k+1])
        );
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            share_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            share_valid_reg <= tok_valid[MAX_THRESHOLD];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && tok_valid[MAX_THRESHOLD])
        begin
            share_reg.share_x    <= tok[MAX_THRESHOLD].x;
            share_reg.share_y    <= tok[MAX_THRESHOLD].y;
            share_reg.last_share <= tok[MAX_THRESHOLD].last;
        end
    end

    assign share_valid = share_valid_reg;
    assign share       = share_reg;

endmodule

// ===== rtl/gss_cell.sv =====
module gss_cell #(
    parameter int COEF_IDX = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            tok_valid,
    input  gss_pkg::token_t tok,
    output logic            out_valid,
    output gss_pkg::token_t out_tok
);

    localparam int IDX_W = $clog2(gss_pkg::NUM_COEFS);

    logic            valid_reg;
    gss_pkg::token_t tok_reg;
    gss_pkg::token_t tok_next;

    // one horner step: y * x + coefficient
    always_comb
    begin
        tok_next   = tok;
        tok_next.y = gss_pkg::gf_mul(tok.y, {4'b0000, tok.x})
                     ^ tok.coefs[IDX_W'(COEF_IDX)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= tok_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && tok_valid)
        begin
            tok_reg <= tok_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_tok   = tok_reg;

endmodule

// ===== rtl/gss_issue.sv =====
module gss_issue #(
    parameter int MAX_THRESHOLD = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic [3:0]        share_count,
    input  logic [3:0]        threshold,
    input  logic              item_valid,
    output logic              item_stall,
    input  gss_pkg::in_word_t item,
    output logic              tok_valid,
    output gss_pkg::token_t   tok
);

    logic               busy_reg;
    logic [3:0]         x_reg;
    logic [3:0]         cnt_reg;
    gss_pkg::coef_vec_t coef_reg;

    logic               last_x;
    logic               accept;
    logic [3:0]         cnt_eff;
    logic [3:0]         terms;
    gss_pkg::coef_vec_t raw;
    gss_pkg::coef_vec_t masked;

    // handshake: take a new word while the last x of the previous one leaves
    always_comb
    begin
        last_x     = (x_reg == cnt_reg);
        item_stall = busy_reg && !(adv && last_x);
        accept     = item_valid && !item_stall;
    end

    // saturate the registers and drop coefficients above the threshold
    always_comb
    begin
        cnt_eff = (share_count > gss_pkg::MAX_SHARES) ? gss_pkg::MAX_SHARES : share_count;
        if (threshold == 4'd0)
        begin
            terms = 4'd1;
        end
        else if (threshold > 4'(MAX_THRESHOLD))
        begin
            terms = 4'(MAX_THRESHOLD);
        end
        else
        begin
            terms = threshold;
        end
        raw[0] = item.secret_byte;
        raw[1] = item.coef_one;
        raw[2] = item.coef_two;
        raw[3] = item.coef_three;
        raw[4] = item.coef_four;
        raw[5] = item.coef_five;
        raw[6] = item.coef_six;
        raw[7] = item.coef_seven;
        for (int i = 0; i < gss_pkg::NUM_COEFS; i++) begin
            masked[i] = (4'(i) < terms) ? raw[i] : 8'h00;
        end
    end

    // x sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            x_reg    <= 4'd1;
            cnt_reg  <= 4'd1;
        end
        else if (accept)
        begin
            busy_reg <= (cnt_eff != 4'd0);
            x_reg    <= 4'd1;
            cnt_reg  <= cnt_eff;
        end
        else if (busy_reg && adv)
        begin
            if (last_x)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                x_reg <= x_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            coef_reg <= masked;
        end
    end

    // token into the first cell, accumulator starts at zero
    always_comb
    begin
        tok_valid = busy_reg;
        tok.x     = x_reg;
        tok.last  = last_x;
        tok.y     = 8'h00;
        tok.coefs = coef_reg;
    end

endmodule

// ===== tb/tb_gf256_shamir_share_split_unit.sv =====
`timescale 1ns / 1ps

module tb_gf256_shamir_share_split_unit;

    localparam int MAX_TERMS = 8;
    // cycles for the horner chain to empty, with margin
    localparam int SETTLE_CYCLES = 3 * (MAX_TERMS + 1);
    localparam int RANDOM_PHASES = 13;
    localparam int PHASE_ITEMS = 30;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               item_valid;
    logic               item_stall;
    gss_pkg::in_word_t  item;
    logic               share_valid;
    logic               share_stall = 1'b0;
    gss_pkg::out_word_t share;

    // shadow of the configuration registers
    logic [3:0]  cur_count = 4'd5;
    logic [3:0]  cur_thresh = 4'd3;
    logic        bursts_on = 1'b1;
    int          stall_left = 0;

    gf256_shamir_share_split_unit #(
        .MAX_THRESHOLD(MAX_TERMS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .share_valid(share_valid),
        .share_stall(share_stall),
        .share(share)
    );

    // expected share words, worked out per accepted item
    class share_predictor;
        gss_pkg::out_word_t due_shares[$];
        int                 mismatches;

        function new();
            mismatches = 0;
        endfunction

        // msb-first multiply in GF(2^8)
        static function logic [7:0] gf_times(logic [7:0] a, logic [7:0] b);
            logic [7:0] acc;
            acc = 8'h00;
            for (int i = 7; i >= 0; i--)
            begin
                acc = {acc[6:0], 1'b0} ^ (acc[7] ? gss_pkg::GF_REDUCE : 8'h00);
                if (b[i])
                begin
                    acc = acc ^ a;
                end
            end
            return acc;
        endfunction

        function void take_item(gss_pkg::in_word_t w, logic [3:0] cnt, logic [3:0] thr);
            logic [7:0]         c [gss_pkg::NUM_COEFS];
            int                 terms;
            int                 shares;
            logic [7:0]         y;
            gss_pkg::out_word_t s;
            c[0] = w.secret_byte;
            c[1] = w.coef_one;
            c[2] = w.coef_two;
            c[3] = w.coef_three;
            c[4] = w.coef_four;
            c[5] = w.coef_five;
            c[6] = w.coef_six;
            c[7] = w.coef_seven;
            // zero threshold acts as one, both limits saturate
            terms = (thr == 4'd0) ? 1 : ((thr > MAX_TERMS) ? MAX_TERMS : int'(thr));
            shares = (cnt > gss_pkg::MAX_SHARES) ? int'(gss_pkg::MAX_SHARES) : int'(cnt);
            for (int x = 1; x <= shares; x++)
            begin
                y = c[terms - 1];
                for (int i = terms - 1; i > 0; i--)
                begin
                    y = gf_times(y, 8'(x)) ^ c[i - 1];
                end
                s.share_x = 4'(x);
                s.share_y = y;
                s.last_share = (x == shares);
                due_shares.push_back(s);
            end
        endfunction

        function void match_share(gss_pkg::out_word_t got);
            gss_pkg::out_word_t want;
            if (due_shares.size() == 0)
            begin
                mismatches++;
                $display("%0t: share word expected none actual x=%0d y=%h last=%b",
                         $time, got.share_x, got.share_y, got.last_share);
                return;
            end
            want = due_shares.pop_front();
            if (got.share_x !== want.share_x)
            begin
                mismatches++;
                $display("%0t: share_x expected %0d actual %0d",
                         $time, want.share_x, got.share_x);
            end
            if (got.share_y !== want.share_y)
            begin
                mismatches++;
                $display("%0t: share_y expected %h actual %h (x=%0d)",
                         $time, want.share_y, got.share_y, want.share_x);
            end
            if (got.last_share !== want.last_share)
            begin
                mismatches++;
                $display("%0t: last_share expected %b actual %b (x=%0d)",
                         $time, want.last_share, got.last_share, want.share_x);
            end
        endfunction
    endclass

    share_predictor ledger = new();

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("gf256_shamir_share_split_unit verification failed");
        $finish;
    end

    // note accepted input words
    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
        begin
            ledger.take_item(item, cur_count, cur_thresh);
        end
    end

    // check accepted share words
    always @(posedge clk)
    begin
        if (rst_n && share_valid && !share_stall)
        begin
            ledger.match_share(share);
        end
    end

    // receiver stall bursts
    always @(posedge clk)
    begin
        if (!rst_n || !bursts_on)
        begin
            stall_left = 0;
            share_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            share_stall <= 1'b1;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(1, 4) - 1;
            share_stall <= 1'b1;
        end
        else
        begin
            share_stall <= 1'b0;
        end
    end

    // write one register through the apb port
    task automatic write_reg(input logic idx, input logic [3:0] val);
        logic [31:0] data;
        data = $urandom();
        data[3:0] = val;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // stop sending and wait for every expected share
    task automatic drain_shares();
        item_valid <= 1'b0;
        @(posedge clk);
        while (ledger.due_shares.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // change the configuration once the block is idle
    task automatic apply_setting(input logic [3:0] cnt, input logic [3:0] thr);
        drain_shares();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(gss_pkg::REG_SHARE_COUNT, cnt);
        write_reg(gss_pkg::REG_THRESHOLD, thr);
        cur_count = cnt;
        cur_thresh = thr;
    endtask

    // present one word, with an occasional gap ahead of it
    task automatic send_item(input gss_pkg::in_word_t w);
        int gap;
        if (bursts_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= w;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
    endtask

    // random bytes, leaning on the field extremes now and then
    function automatic gss_pkg::in_word_t rand_item();
        logic [63:0] raw;
        for (int i = 0; i < gss_pkg::NUM_COEFS; i++)
        begin
            case ($urandom_range(0, 9))
                0: raw[8*i +: 8] = 8'h00;
                1: raw[8*i +: 8] = 8'hFF;
                2: raw[8*i +: 8] = 8'h80;
                default: raw[8*i +: 8] = 8'($urandom());
            endcase
        end
        return gss_pkg::in_word_t'(raw);
    endfunction

    function automatic logic [3:0] rand_setting();
        case ($urandom_range(0, 9))
            0: return 4'($urandom_range(9, 15));
            1: return 4'd0;
            default: return 4'($urandom_range(1, 8));
        endcase
    endfunction

    initial
    begin
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        item_valid <= 1'b0;
        item <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: five shares, threshold three
        send_item(64'h0000_0000_0000_0000);
        send_item(64'hFFFF_FFFF_FFFF_FFFF);
        send_item(64'hAA55_AA55_AA55_AA55);
        send_item(64'h55AA_55AA_55AA_55AA);

        // full polynomial at every point
        apply_setting(4'd8, 4'd8);
        send_item(64'h8080_8080_8080_8080);
        send_item(64'h0000_0000_0000_00FF);
        send_item(64'h0102_0408_1020_4080);
        send_item(64'hFFFF_FFFF_FFFF_FFFF);

        // threshold one: shares copy the secret
        apply_setting(4'd1, 4'd1);
        send_item(64'hC3FF_FFFF_FFFF_FFFF);
        send_item(rand_item());

        // zero share count: no words at all
        apply_setting(4'd0, 4'd3);
        send_item(64'hFFFF_FFFF_FFFF_FFFF);
        send_item(rand_item());

        // both registers above their limits
        apply_setting(4'd15, 4'd15);
        send_item(64'h8080_8080_8080_8080);
        send_item(rand_item());

        // zero threshold
        apply_setting(4'd8, 4'd0);
        send_item(64'h5A12_3456_789A_BCDE);
        send_item(rand_item());

        apply_setting(4'd9, 4'd2);
        send_item(64'h01FF_FFFF_FFFF_FFFF);
        send_item(rand_item());

        // random phases, the last ones without any idling
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph == 5)
            begin
                apply_setting(4'd8, 4'd8);
            end
            else
            begin
                apply_setting(rand_setting(), rand_setting());
            end
            if (ph >= RANDOM_PHASES - 3)
            begin
                bursts_on = 1'b0;
            end
            else
            begin
                bursts_on = ($urandom_range(0, 4) != 0);
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // hold off mid-phase until the block has caught up
                if (ph == 5 && n == PHASE_ITEMS / 2)
                begin
                    drain_shares();
                end
                send_item(rand_item());
            end
        end

        drain_shares();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (ledger.mismatches == 0 && ledger.due_shares.size() == 0)
        begin
            $display("gf256_shamir_share_split_unit verification clean");
        end
        else
        begin
            $display("gf256_shamir_share_split_unit verification failed");
        end
        $finish;
    end

endmodule

// ===== gf256_shamir_share_split_unit.f =====
rtl/gss_pkg.sv
rtl/gss_cell.sv
rtl/gss_issue.sv
rtl/gf256_shamir_share_split_unit.sv
tb/tb_gf256_shamir_share_split_unit.sv
